[rtl/mcfr_pkg.sv]
// ----------------------------------------------------------------------------
// mcfr_pkg - shared types and constants of the marker frame receiver
// Request and result records, configuration record, header layout and the
// bytewise CRC-16/ARC update.
// ----------------------------------------------------------------------------
package mcfr_pkg;

  localparam int unsigned BUFFER_DEPTH = 512;
  localparam int unsigned HDR_LEN      = 10;
  localparam int unsigned MAX_RESULTS  = 64;

  localparam logic [7:0]  MARK_CHAR     = 8'h3E;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  // Register index codes of the configuration channel.
  localparam logic [0:0] CFG_OWN_SYS_ID = 1'b0;
  localparam logic [0:0] CFG_MAX_LEN    = 1'b1;

  // Byte positions inside the header, counted from the first marker byte.
  localparam int unsigned HDR_TOPIC  = 3;
  localparam int unsigned HDR_SYSID  = 4;
  localparam int unsigned HDR_LEN_HI = 6;
  localparam int unsigned HDR_LEN_LO = 7;
  localparam int unsigned HDR_CRC_HI = 8;
  localparam int unsigned HDR_CRC_LO = 9;

  typedef enum logic [2:0] {
    EV_GOOD      = 3'd0,
    EV_BAD_CRC   = 3'd1,
    EV_OWN_SYS   = 3'd2,
    EV_TOO_LONG  = 3'd3,
    EV_DATA_BYTE = 3'd4
  } ev_kind_e;

  typedef struct packed {
    logic       is_read;
    logic [7:0] rx_byte;
    logic [8:0] idx;
  } req_t;

  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] topic;
    logic [8:0] plen;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] own_id;
    logic [9:0] max_len;
  } cfg_t;

  // One byte through the reflected CRC-16/ARC register.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/marker_crc16_frame_receiver.sv]
// ----------------------------------------------------------------------------
// marker_crc16_frame_receiver - framed byte stream receiver
// Hunts for the start marker, checks header and CRC-16/ARC of each frame and
// keeps the payload of the last good frame for read back.
// ----------------------------------------------------------------------------
// Usage: every request on the slave stream either pushes one received link
// byte (tuser 0) or reads one byte of the last good payload (tuser 1). A
// pushed byte may cause any number of results (good frame, bad CRC, own
// system echo, too long), at most 64; a read causes exactly one. tlast marks
// the last result of a request; a push that completes nothing gives none.
// A read back reads the payload store. A push with no frame in sight
// runs the marker scan over the receive store; a found frame adds the
// header and its checks, the CRC pass over the payload and, when good,
// the copy, and each dropped frame starts a new scan one byte past its
// marker. The receive store has a single read port. Two requests queue
// ahead of the engine, and a result waits in an output register, so a
// stalled master side only holds the engine once it has another result
// to hand over. Configuration is written through its own channel, which
// is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. Reset empties the receive store
// and clears the good payload length; both stores need no clearing pass.
// ----------------------------------------------------------------------------
module marker_crc16_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = mcfr_pkg::BUFFER_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], payload_index[16:8], zero
  output logic        s_axis_tready,
  input  logic [0:0]  s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // topic_number[7:0], pay_len[16:8],
                                      // data_byte[24:17], zero
  output logic [2:0]  m_axis_tuser,   // event_kind[2:0]
  output logic        m_axis_tlast,   // last_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  mcfr_pkg::cfg_t cfg_q, cfg_d;
  logic           req_valid, req_ready;
  mcfr_pkg::req_t req;
  mcfr_pkg::res_t res;

  // The configuration registers accept a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mcfr_pkg::CFG_OWN_SYS_ID: cfg_d.own_id  = cfg_data_i[7:0];
        mcfr_pkg::CFG_MAX_LEN:    cfg_d.max_len = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{own_id: 8'd1, max_len: 10'd512};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: request queue and decode.
  mcfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[0]),
    .rx_byte_i   (s_axis_tdata[7:0]),
    .idx_i       (s_axis_tdata[16:8]),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  // Back: stores, frame evaluation and result register.
  mcfr_engine #(
    .DEPTH (BUFFER_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {7'b0, res.data, res.plen, res.topic};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

[rtl/mcfr_front.sv]
// ----------------------------------------------------------------------------
// mcfr_front - request intake
// Two-entry queue that takes stream requests, decodes them into push or
// read-back requests and holds them until the engine is free.
// ----------------------------------------------------------------------------
module mcfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [8:0]    idx_i,
  output logic          req_valid_o,
  input  logic          req_ready_i,
  output mcfr_pkg::req_t req_o
);

  mcfr_pkg::req_t fifo_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = fifo_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= '{is_read: action_i, rx_byte: rx_byte_i, idx: idx_i};
    end
  end

endmodule

[rtl/mcfr_engine.sv]
// ----------------------------------------------------------------------------
// mcfr_engine - frame evaluation engine
// Circular receive store, marker scan, header checks, CRC pass, payload copy
// and result sequencing with one pending result to mark the last one.
// ----------------------------------------------------------------------------
module mcfr_engine #(
  parameter int unsigned DEPTH = mcfr_pkg::BUFFER_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcfr_pkg::cfg_t cfg_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  mcfr_pkg::req_t req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mcfr_pkg::res_t out_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = 18;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_RD      = 11'b000_0000_0010,
    S_EVAL    = 11'b000_0000_0100,
    S_SCAN    = 11'b000_0000_1000,
    S_HDR     = 11'b000_0001_0000,
    S_CHECK   = 11'b000_0010_0000,
    S_CRC     = 11'b000_0100_0000,
    S_VERDICT = 11'b000_1000_0000,
    S_COPY    = 11'b001_0000_0000,
    S_GOOD    = 11'b010_0000_0000,
    S_FINISH  = 11'b100_0000_0000
  } state_e;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] b, logic [CW-1:0] o);
    logic [CW:0] t;
    t = (CW+1)'(b) + (CW+1)'(o);
    if (t >= (CW+1)'(DEPTH)) begin
      t = t - (CW+1)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  state_e         state_q, state_d;
  logic [AW-1:0]  head_q, head_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic [CW-1:0]  good_len_q, good_len_d;
  logic [CW-1:0]  ia_q, ia_d;
  logic [1:0]     run_q, run_d;
  logic [CW-1:0]  s_q, s_d;
  logic [7:0]     topic_q, topic_d, sys_q, sys_d;
  logic [7:0]     ph_q, ph_d, pl_q, pl_d, ch_q, ch_d, cl_q, cl_d;
  logic [15:0]    crc_q, crc_d;
  logic [6:0]     cnt_q, cnt_d;
  logic           pend_v_q, pend_v_d;
  mcfr_pkg::res_t pend_q, pend_d;
  logic           out_v_q, out_v_d;
  mcfr_pkg::res_t out_q, out_d;
  logic [8:0]     idx_q, idx_d;

  // Receive store read path.
  logic [7:0]     rx_mem [DEPTH];
  logic [7:0]     rx_rdata_q;
  logic           rv_q;
  logic [CW-1:0]  roff_q;
  logic           rd_en;
  logic           rx_we;
  // Payload store.
  logic [7:0]     pl_mem [DEPTH];
  logic [7:0]     pl_rdata_q;
  logic           pl_we;
  logic [AW-1:0]  pl_waddr;
  logic           pl_rd_en;

  logic [15:0]    plen16;
  logic [XW-1:0]  fe_w;
  logic [CW-1:0]  fe;
  logic [CW-1:0]  lim;
  logic [CW-1:0]  hoff;
  logic           out_free;
  logic           ev_stall;
  logic           ev_fire;
  mcfr_pkg::res_t ev_res;
  logic           push_en;
  mcfr_pkg::res_t push_res;
  logic           disc_en;
  logic [CW-1:0]  disc_n;
  logic           found;
  logic           hit;

  assign plen16   = {ph_q, pl_q};
  assign fe_w     = XW'(s_q) + XW'(mcfr_pkg::HDR_LEN) + XW'(plen16);
  assign fe       = fe_w[CW-1:0];
  assign lim      = fill_q - CW'(8);
  assign hoff     = roff_q - s_q;
  assign out_free = !out_v_q || out_ready_i;
  assign ev_stall = pend_v_q && !out_free && (cnt_q < 7'(mcfr_pkg::MAX_RESULTS));
  assign found    = (rx_rdata_q == mcfr_pkg::MARK_CHAR) && (run_q >= 2'd2);
  assign hit      = (XW'(idx_q) < XW'(good_len_q)) && (XW'(idx_q) < XW'(DEPTH));
  assign pl_waddr = AW'(roff_q - s_q - CW'(mcfr_pkg::HDR_LEN));

  assign req_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fill_d     = fill_q;
    good_len_d = good_len_q;
    ia_d       = ia_q;
    run_d      = run_q;
    s_d        = s_q;
    topic_d    = topic_q;
    sys_d      = sys_q;
    ph_d       = ph_q;
    pl_d       = pl_q;
    ch_d       = ch_q;
    cl_d       = cl_q;
    crc_d      = crc_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    idx_d      = idx_q;
    rd_en      = 1'b0;
    rx_we      = 1'b0;
    pl_we      = 1'b0;
    pl_rd_en   = 1'b0;
    ev_fire    = 1'b0;
    ev_res     = '{kind: mcfr_pkg::EV_GOOD, topic: 8'h00, plen: plen16[8:0],
                   data: 8'h00, last: 1'b0};
    push_en    = 1'b0;
    push_res   = pend_q;
    disc_en    = 1'b0;
    disc_n     = '0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cnt_d = '0;
          if (req_i.is_read) begin
            pl_rd_en = 1'b1;
            idx_d    = req_i.idx;
            state_d  = S_RD;
          end else begin
            if (fill_q < CW'(DEPTH)) begin
              rx_we  = 1'b1;
              fill_d = fill_q + CW'(1);
            end
            state_d = S_EVAL;
          end
        end
      end
      S_RD: begin
        if (out_free) begin
          push_en  = 1'b1;
          push_res = '{kind: mcfr_pkg::EV_DATA_BYTE, topic: 8'h00,
                       plen: 9'(good_len_q), data: hit ? pl_rdata_q : 8'h00,
                       last: 1'b1};
          state_d  = S_IDLE;
        end
      end
      S_EVAL: begin
        if (fill_q < CW'(mcfr_pkg::HDR_LEN)) begin
          state_d = S_FINISH;
        end else begin
          ia_d    = '0;
          run_d   = 2'd0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = (ia_q <= lim);
        if (rd_en) begin
          ia_d = ia_q + CW'(1);
        end
        if (rv_q) begin
          if (found) begin
            s_d     = roff_q - CW'(2);
            ia_d    = roff_q + CW'(1);
            rd_en   = 1'b0;
            state_d = S_HDR;
          end else if (roff_q == lim) begin
            // No marker anywhere: keep only the tail that may still start one.
            disc_en = 1'b1;
            disc_n  = fill_q - CW'(mcfr_pkg::HDR_LEN - 1);
            rd_en   = 1'b0;
            state_d = S_FINISH;
          end else if (rx_rdata_q == mcfr_pkg::MARK_CHAR) begin
            run_d = run_q + 2'd1;
          end else begin
            run_d = 2'd0;
          end
        end
      end
      S_HDR: begin
        rd_en = (ia_q <= s_q + CW'(mcfr_pkg::HDR_LEN - 1));
        if (rd_en) begin
          ia_d = ia_q + CW'(1);
        end
        if (rv_q) begin
          if (hoff == CW'(mcfr_pkg::HDR_TOPIC))  topic_d = rx_rdata_q;
          if (hoff == CW'(mcfr_pkg::HDR_SYSID))  sys_d   = rx_rdata_q;
          if (hoff == CW'(mcfr_pkg::HDR_LEN_HI)) ph_d    = rx_rdata_q;
          if (hoff == CW'(mcfr_pkg::HDR_LEN_LO)) pl_d    = rx_rdata_q;
          if (hoff == CW'(mcfr_pkg::HDR_CRC_HI)) ch_d    = rx_rdata_q;
          if (hoff == CW'(mcfr_pkg::HDR_CRC_LO)) begin
            cl_d    = rx_rdata_q;
            rd_en   = 1'b0;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sys_q == cfg_i.own_id) begin
          if (!ev_stall) begin
            ev_fire     = 1'b1;
            ev_res.kind = mcfr_pkg::EV_OWN_SYS;
            disc_en     = 1'b1;
            disc_n      = s_q + CW'(1);
            state_d     = S_EVAL;
          end
        end else if (XW'(cfg_i.max_len) < XW'(mcfr_pkg::HDR_LEN) + XW'(plen16)) begin
          if (!ev_stall) begin
            ev_fire     = 1'b1;
            ev_res.kind = mcfr_pkg::EV_TOO_LONG;
            disc_en     = 1'b1;
            disc_n      = s_q + CW'(1);
            state_d     = S_EVAL;
          end
        end else if (fe_w > XW'(fill_q)) begin
          // Frame not complete yet: drop only the garbage ahead of it.
          disc_en = 1'b1;
          disc_n  = s_q;
          state_d = S_FINISH;
        end else begin
          crc_d = 16'h0000;
          ia_d  = s_q + CW'(mcfr_pkg::HDR_LEN);
          state_d = (plen16 == 16'h0000) ? S_VERDICT : S_CRC;
        end
      end
      S_CRC: begin
        rd_en = (ia_q < fe);
        if (rd_en) begin
          ia_d = ia_q + CW'(1);
        end
        if (rv_q) begin
          crc_d = mcfr_pkg::crc_byte(crc_q, rx_rdata_q);
          if (roff_q == fe - CW'(1)) begin
            rd_en   = 1'b0;
            state_d = S_VERDICT;
          end
        end
      end
      S_VERDICT: begin
        if (crc_q != {ch_q, cl_q}) begin
          if (!ev_stall) begin
            ev_fire     = 1'b1;
            ev_res.kind = mcfr_pkg::EV_BAD_CRC;
            disc_en     = 1'b1;
            disc_n      = s_q + CW'(1);
            state_d     = S_EVAL;
          end
        end else begin
          good_len_d = plen16[CW-1:0];
          ia_d       = s_q + CW'(mcfr_pkg::HDR_LEN);
          state_d    = (plen16 == 16'h0000) ? S_GOOD : S_COPY;
        end
      end
      S_COPY: begin
        rd_en = (ia_q < fe);
        if (rd_en) begin
          ia_d = ia_q + CW'(1);
        end
        if (rv_q) begin
          pl_we = 1'b1;
          if (roff_q == fe - CW'(1)) begin
            rd_en   = 1'b0;
            state_d = S_GOOD;
          end
        end
      end
      S_GOOD: begin
        if (!ev_stall) begin
          ev_fire      = 1'b1;
          ev_res.kind  = mcfr_pkg::EV_GOOD;
          ev_res.topic = topic_q;
          disc_en      = 1'b1;
          disc_n       = fe;
          state_d      = S_EVAL;
        end
      end
      S_FINISH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          push_en       = 1'b1;
          push_res      = pend_q;
          push_res.last = 1'b1;
          pend_v_d      = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Events past the result limit are evaluated but not reported.
    if (ev_fire && (cnt_q < 7'(mcfr_pkg::MAX_RESULTS))) begin
      if (pend_v_q) begin
        push_en  = 1'b1;
        push_res = pend_q;
      end
      pend_v_d = 1'b1;
      pend_d   = ev_res;
      cnt_d    = cnt_q + 7'd1;
    end

    if (disc_en) begin
      head_d = wrap_add(head_q, disc_n);
      fill_d = fill_q - disc_n;
    end

    out_v_d = out_v_q && !out_ready_i;
    out_d   = out_q;
    if (push_en) begin
      out_v_d = 1'b1;
      out_d   = push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      fill_q     <= '0;
      good_len_q <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      fill_q     <= fill_d;
      good_len_q <= good_len_d;
      cnt_q      <= cnt_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      rv_q       <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    ia_q    <= ia_d;
    run_q   <= run_d;
    s_q     <= s_d;
    topic_q <= topic_d;
    sys_q   <= sys_d;
    ph_q    <= ph_d;
    pl_q    <= pl_d;
    ch_q    <= ch_d;
    cl_q    <= cl_d;
    crc_q   <= crc_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
    idx_q   <= idx_d;
    if (rd_en) begin
      roff_q <= ia_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[wrap_add(head_q, fill_q)] <= req_i.rx_byte;
    end
    if (rd_en) begin
      rx_rdata_q <= rx_mem[wrap_add(head_q, ia_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pl_mem[pl_waddr] <= rx_rdata_q;
    end
    if (pl_rd_en) begin
      pl_rdata_q <= pl_mem[AW'(req_i.idx)];
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_v_q)
    else $error("pending result left over at idle");

  a_result_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(mcfr_pkg::MAX_RESULTS))
    else $error("result count beyond limit");

  a_read_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == S_SCAN || state_q == S_HDR || state_q == S_CRC ||
              state_q == S_COPY))
    else $error("receive store data returned outside a read phase");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (fill_q <= CW'(DEPTH)) && (head_q < AW'(DEPTH - 1) + AW'(1)
      || AW'(DEPTH) == '0))
    else $error("receive store pointers out of range");
`endif

endmodule
